// ===== src/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg
// Types, constants and helpers shared by the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int SLOTS    = 64;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int GEN_W    = 16;
  localparam int CNT_W    = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_DESTROY = 2'd1,
    KIND_CHECK   = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  handle_index;
    logic [GEN_W-1:0]  handle_generation;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  out_index;
    logic [GEN_W-1:0]  out_generation;
    logic [CNT_W-1:0]  live_count;
  } out_t;

  // one slot table entry
  typedef struct packed {
    logic              live;
    logic [GEN_W-1:0]  gen;
  } slot_entry_t;

  // free stack entry keeps the generation so a pop needs no second lookup
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  gen;
  } stack_entry_t;

  localparam int SLOT_ENTRY_W  = $bits(slot_entry_t);
  localparam int STACK_ENTRY_W = $bits(stack_entry_t);

  // next generation, zero skipped
  function automatic logic [GEN_W-1:0] gen_bump(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + 1'b1;
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

endpackage

// ===== src/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Slot map handing out (index, generation) handles with a LIFO free stack.
// ----------------------------------------------------------------------------
// a request is registered into stage one together with the table read, then into the
// result register; one request per cycle, busy never rises
// slot table and free stack reads are forwarded from the write of the request
// ahead of it, so back-to-back requests see each other's updates
// reset clears the slot, stack and live counters; table contents are untouched
module generational_handle_allocator
  import gha_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  logic accept;

  logic s1_valid_r;
  in_t  s1_req_r;

  logic [CNT_W-1:0] slots_used_r, slots_used_nxt;
  logic [CNT_W-1:0] free_top_r, free_top_nxt;
  logic [CNT_W-1:0] live_total_r, live_total_nxt;

  logic         out_valid_r;
  out_t         out_data_r, out_data_nxt;

  // slot table port signals
  logic             slot_we;
  logic [IDX_W-1:0] slot_waddr;
  slot_entry_t      slot_wdata;
  logic [IDX_W-1:0] slot_raddr;
  slot_entry_t      slot_rdata;
  logic             slot_fwd_r;
  slot_entry_t      slot_fwd_data_r;
  slot_entry_t      slot_q;

  // free stack port signals
  logic             stack_we;
  logic [IDX_W-1:0] stack_waddr;
  stack_entry_t     stack_wdata;
  logic [IDX_W-1:0] stack_raddr;
  stack_entry_t     stack_rdata;
  logic             stack_fwd_r;
  stack_entry_t     stack_fwd_data_r;
  stack_entry_t     stack_q;

  logic             in_range;
  logic             hit;
  logic [GEN_W-1:0] slot_bumped;
  logic [GEN_W-1:0] stack_bumped;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  gha_ram #(
    .WIDTH (SLOT_ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  gha_ram #(
    .WIDTH (STACK_ENTRY_W),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  // reads are issued as the request is accepted; stack top follows the
  // update of the request now in flight
  assign slot_raddr  = in_data.handle_index;
  assign stack_raddr = IDX_W'(free_top_nxt - 1'b1);

  assign slot_q  = slot_fwd_r  ? slot_fwd_data_r  : slot_rdata;
  assign stack_q = stack_fwd_r ? stack_fwd_data_r : stack_rdata;

  assign in_range     = {1'b0, s1_req_r.handle_index} < slots_used_r;
  assign hit          = in_range && slot_q.live &&
                        (slot_q.gen == s1_req_r.handle_generation);
  assign slot_bumped  = gen_bump(slot_q.gen);
  assign stack_bumped = gen_bump(stack_q.gen);

  always_comb begin
    slots_used_nxt = slots_used_r;
    free_top_nxt   = free_top_r;
    live_total_nxt = live_total_r;
    slot_we        = 1'b0;
    slot_waddr     = s1_req_r.handle_index;
    slot_wdata     = '{live: 1'b0, gen: slot_bumped};
    stack_we       = 1'b0;
    stack_waddr    = free_top_r[IDX_W-1:0];
    stack_wdata    = '{idx: s1_req_r.handle_index, gen: slot_bumped};
    out_data_nxt.status         = ST_OK;
    out_data_nxt.out_index      = s1_req_r.handle_index;
    out_data_nxt.out_generation = '0;
    out_data_nxt.live_count     = '0;

    if (s1_valid_r) begin
      unique case (s1_req_r.kind)
        KIND_CREATE: begin
          if (free_top_r != '0) begin
            // reuse the most recently freed slot
            free_top_nxt                = free_top_r - 1'b1;
            slot_we                     = 1'b1;
            slot_waddr                  = stack_q.idx;
            slot_wdata                  = '{live: 1'b1, gen: stack_bumped};
            live_total_nxt              = live_total_r + 1'b1;
            out_data_nxt.out_index      = stack_q.idx;
            out_data_nxt.out_generation = stack_bumped;
          end else if (slots_used_r != CNT_W'(SLOTS)) begin
            slots_used_nxt              = slots_used_r + 1'b1;
            slot_we                     = 1'b1;
            slot_waddr                  = slots_used_r[IDX_W-1:0];
            slot_wdata                  = '{live: 1'b1, gen: GEN_W'(1)};
            live_total_nxt              = live_total_r + 1'b1;
            out_data_nxt.out_index      = slots_used_r[IDX_W-1:0];
            out_data_nxt.out_generation = GEN_W'(1);
          end else begin
            out_data_nxt.status         = ST_FULL;
            out_data_nxt.out_index      = '0;
          end
        end
        KIND_DESTROY, KIND_CHECK: begin
          if (!hit) begin
            out_data_nxt.status         = ST_STALE;
            out_data_nxt.out_generation = in_range ? slot_q.gen : '0;
          end else if (s1_req_r.kind == KIND_DESTROY) begin
            slot_we = 1'b1;
            if (free_top_r != CNT_W'(SLOTS)) begin
              stack_we     = 1'b1;
              free_top_nxt = free_top_r + 1'b1;
            end
            if (live_total_r != '0) begin
              live_total_nxt = live_total_r - 1'b1;
            end
            out_data_nxt.out_generation = slot_bumped;
          end else begin
            out_data_nxt.out_generation = slot_q.gen;
          end
        end
        KIND_CLEAR: begin
          slots_used_nxt         = '0;
          free_top_nxt           = '0;
          live_total_nxt         = '0;
          out_data_nxt.out_index = '0;
        end
        default: begin
          out_data_nxt.status = ST_OK;
        end
      endcase
    end

    out_data_nxt.live_count = live_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      slots_used_r <= '0;
      free_top_r   <= '0;
      live_total_r <= '0;
      out_valid_r  <= 1'b0;
      slot_fwd_r   <= 1'b0;
      stack_fwd_r  <= 1'b0;
    end else begin
      s1_valid_r   <= accept;
      slots_used_r <= slots_used_nxt;
      free_top_r   <= free_top_nxt;
      live_total_r <= live_total_nxt;
      out_valid_r  <= s1_valid_r;
      // write and read of the same entry on one edge: take the new data
      slot_fwd_r   <= slot_we && (slot_waddr == slot_raddr);
      stack_fwd_r  <= stack_we && (stack_waddr == stack_raddr);
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r         <= in_data;
    out_data_r       <= out_data_nxt;
    slot_fwd_data_r  <= slot_wdata;
    stack_fwd_data_r <= stack_wdata;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/gha_ram.sv =====
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/gha_checker.sv =====
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks for the generational handle allocator, bound to the top.
// ----------------------------------------------------------------------------
module gha_checker
  import gha_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  // every transfer in gives exactly one result from the result register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("missing result after request");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##2 !out_valid)
    else $error("result without request");

  // table full means every slot is live
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.live_count == CNT_W'(SLOTS)))
    else $error("full reported with free slots");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.kind == KIND_CLEAR) |-> ##2
      (out_data.status == ST_OK && out_data.live_count == '0 &&
       out_data.out_generation == '0))
    else $error("clear did not empty the table");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.live_count <= CNT_W'(SLOTS)))
    else $error("live count above slot count");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);
